[sv/lfc_pkg.sv]
package lfc_pkg;

	localparam int PARTITION_LEN   = 64;
	localparam int TAIL_PARTITIONS = 16;
	localparam int TAPS            = PARTITION_LEN * (1 + TAIL_PARTITIONS);

	localparam int ADDR_W = 11;
	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = 40;
	localparam int SHIFT  = 15;
	localparam int RND_W  = ACC_W + 1;
	localparam int Q_W    = RND_W - SHIFT;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPS - 1);
	localparam logic [ADDR_W-1:0] TAP_LIMIT = ADDR_W'(TAPS);

	localparam logic KIND_TAP    = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic start;
		logic rd_vld;
		logic rd_last;
		logic take;
	} mac_ctrl_t;

	typedef struct packed {
		logic  done;
		data_t sample;
		logic  clip;
	} mac_res_t;

endpackage

[sv/lfc_mac.sv]
module lfc_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  lfc_pkg::mac_ctrl_t ctrl,
	input  lfc_pkg::data_t    tap_rd,
	input  lfc_pkg::data_t    hist_rd,
	output lfc_pkg::mac_res_t res
);

	logic signed [lfc_pkg::PROD_W-1:0] prod_s2;
	logic                              vld_s2;
	logic                              last_s2;
	logic signed [lfc_pkg::ACC_W-1:0]  acc_q;
	logic                              done_q;

	logic signed [lfc_pkg::RND_W-1:0]  rnd;
	logic signed [lfc_pkg::Q_W-1:0]    q;

	always_ff @(posedge clk) begin
		prod_s2 <= tap_rd * hist_rd;
		if (ctrl.start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(lfc_pkg::ACC_W-lfc_pkg::PROD_W){prod_s2[lfc_pkg::PROD_W-1]}},
				prod_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s2  <= ctrl.rd_vld;
			last_s2 <= ctrl.rd_vld & ctrl.rd_last;
			if (vld_s2 && last_s2) begin
				done_q <= 1'b1;
			end else if (ctrl.take) begin
				done_q <= 1'b0;
			end
		end
	end

	// round half up, floor shift, saturate
	always_comb begin
		rnd = {acc_q[lfc_pkg::ACC_W-1], acc_q} + lfc_pkg::RND_W'(16384);
		q   = rnd[lfc_pkg::RND_W-1:lfc_pkg::SHIFT];
		res.done = done_q;
		if (q > lfc_pkg::Q_W'(32767)) begin
			res.sample = 16'sh7fff;
			res.clip   = 1'b1;
		end else if (q < -(lfc_pkg::Q_W'(32768))) begin
			res.sample = 16'sh8000;
			res.clip   = 1'b1;
		end else begin
			res.sample = q[lfc_pkg::DATA_W-1:0];
			res.clip   = 1'b0;
		end
	end

endmodule

[sv/long_fir_convolver_core.sv]
// Long FIR convolver: output = sum of all 1088 taps times the most recent
// 1088 input samples, Q1.15, 40-bit accumulate, rounded half up and
// saturated to 16 bits (clipped flags saturation).
// Input channel: in_valid / in_stall. kind 0 writes one tap (tap_index,
// tap_value); indexes of 1088 and above are dropped. kind 1 pushes one
// sample (sample_in) and yields exactly one output request.
// Output channel: out_valid / out_stall, held in an output register.
// Tap write: no output, and in_stall stays low. Sample: one multiply-accumulate per tap
// from the tap and history memories (one read port each); the reads, the product
// and the accumulator are registered, and the rounded result then loads into the
// output register. A new sample is taken only after that load.
// A finished result waits in the output register while the next request is
// taken; beyond the accumulation, in_stall stays high only while a new
// result is ready and the previous one is still stalled.
// Reset: both memories are swept to zero, one entry a cycle, over all 1088
// entries, with in_stall high throughout; the history pointer restarts at slot 0.
module long_fir_convolver_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  lfc_pkg::addr_t      tap_index,
	input  lfc_pkg::data_t      tap_value,
	input  lfc_pkg::data_t      sample_in,
	output logic                out_valid,
	input  logic                out_stall,
	output lfc_pkg::data_t      sample_out,
	output logic                clipped
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	state_t state_q;

	lfc_pkg::addr_t clr_cnt_q;
	lfc_pkg::addr_t ptr_q;
	lfc_pkg::addr_t k_q;
	lfc_pkg::addr_t slot_q;

	lfc_pkg::data_t tap_mem  [lfc_pkg::TAPS];
	lfc_pkg::data_t hist_mem [lfc_pkg::TAPS];

	lfc_pkg::data_t tap_rd_s1;
	lfc_pkg::data_t hist_rd_s1;
	logic           vld_s1;
	logic           last_s1;

	logic           accept;
	logic           tap_we;
	lfc_pkg::addr_t tap_wa;
	lfc_pkg::data_t tap_wd;
	logic           hist_we;
	lfc_pkg::addr_t hist_wa;
	lfc_pkg::data_t hist_wd;
	logic           out_free;
	logic           take;

	lfc_pkg::mac_ctrl_t mac_ctrl;
	lfc_pkg::mac_res_t  mac_res;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign take     = (state_q == ST_DRAIN) && mac_res.done && out_free;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			tap_we  = 1'b1;
			tap_wa  = clr_cnt_q;
			tap_wd  = '0;
			hist_we = 1'b1;
			hist_wa = clr_cnt_q;
			hist_wd = '0;
		end else begin
			tap_we  = accept && (kind == lfc_pkg::KIND_TAP) && (tap_index < lfc_pkg::TAP_LIMIT);
			tap_wa  = tap_index;
			tap_wd  = tap_value;
			hist_we = accept && (kind == lfc_pkg::KIND_SAMPLE);
			hist_wa = ptr_q;
			hist_wd = sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_wa] <= tap_wd;
		end
		tap_rd_s1 <= tap_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd_s1 <= hist_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			ptr_q      <= '0;
			k_q        <= '0;
			slot_q     <= '0;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			out_valid  <= 1'b0;
			sample_out <= '0;
			clipped    <= 1'b0;
		end else begin
			vld_s1  <= (state_q == ST_MAC);
			last_s1 <= (k_q == lfc_pkg::LAST_ADDR);
			if (out_valid && !out_stall && !take) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + lfc_pkg::ADDR_W'(1);
					if (clr_cnt_q == lfc_pkg::LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (kind == lfc_pkg::KIND_SAMPLE)) begin
						k_q    <= '0;
						slot_q <= ptr_q;
						ptr_q  <= (ptr_q == lfc_pkg::LAST_ADDR) ? '0 :
							ptr_q + lfc_pkg::ADDR_W'(1);
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					k_q    <= (k_q == lfc_pkg::LAST_ADDR) ? '0 : k_q + lfc_pkg::ADDR_W'(1);
					slot_q <= (slot_q == '0) ? lfc_pkg::LAST_ADDR :
						slot_q - lfc_pkg::ADDR_W'(1);
					if (k_q == lfc_pkg::LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (take) begin
						out_valid  <= 1'b1;
						sample_out <= mac_res.sample;
						clipped    <= mac_res.clip;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		mac_ctrl.start   = accept && (kind == lfc_pkg::KIND_SAMPLE);
		mac_ctrl.rd_vld  = vld_s1;
		mac_ctrl.rd_last = last_s1;
		mac_ctrl.take    = take;
	end

	lfc_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.tap_rd  (tap_rd_s1),
		.hist_rd (hist_rd_s1),
		.res     (mac_res)
	);

endmodule

[sv/lfc_checker.sv]
module lfc_props (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           kind,
	input logic           out_valid,
	input logic           out_stall,
	input lfc_pkg::data_t sample_out,
	input logic           clipped
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(clipped))
		else $error("stalled output request changed");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (sample_out == 16'sh7fff) || (sample_out == 16'sh8000))
		else $error("clipped output not at a rail");

	a_tap_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (kind == lfc_pkg::KIND_TAP) |=> !in_stall)
		else $error("tap write did not complete in one cycle");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (kind == lfc_pkg::KIND_SAMPLE) |=> in_stall)
		else $error("sample request did not start accumulation");

	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output appeared without accumulation");

endmodule

bind long_fir_convolver_core lfc_props u_lfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.kind       (kind),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.clipped    (clipped)
);

[dv/lfc_checker.sv]
module lfc_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           kind,
	input  lfc_pkg::addr_t tap_index,
	input  lfc_pkg::data_t tap_value,
	input  lfc_pkg::data_t sample_in,
	input  logic           out_valid,
	input  logic           out_stall,
	input  lfc_pkg::data_t sample_out,
	input  logic           clipped,
	output int             fail_count,
	output int             backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		lfc_pkg::data_t sample;
		logic           clip;
	} conv_out_t;

	localparam logic signed [lfc_pkg::RND_W-1:0] HALF_LSB =
		lfc_pkg::RND_W'(1) <<< (lfc_pkg::SHIFT - 1);
	localparam logic signed [lfc_pkg::Q_W-1:0]   Q_MAX    = lfc_pkg::Q_W'(32767);
	localparam logic signed [lfc_pkg::Q_W-1:0]   Q_MIN    = lfc_pkg::Q_W'(-32768);

	lfc_pkg::data_t coef_mem [lfc_pkg::TAPS];
	lfc_pkg::data_t hist_mem [lfc_pkg::TAPS];
	int             hist_slot;
	conv_out_t      expected_outputs [$];
	conv_out_t      head;

	// newest sample must already sit in hist_mem[hist_slot]
	function automatic conv_out_t convolve_history();
		logic signed [lfc_pkg::ACC_W-1:0]  acc;
		logic signed [lfc_pkg::PROD_W-1:0] prod;
		logic signed [lfc_pkg::RND_W-1:0]  rnd;
		logic signed [lfc_pkg::Q_W-1:0]    q;
		int                                slot;
		conv_out_t                         res;
		acc  = '0;
		slot = hist_slot;
		for (int k = 0; k < lfc_pkg::TAPS; k++) begin
			prod = coef_mem[k] * hist_mem[slot];
			acc  = acc + lfc_pkg::ACC_W'(prod);
			slot = (slot == 0) ? lfc_pkg::TAPS - 1 : slot - 1;
		end
		rnd = lfc_pkg::RND_W'(acc) + HALF_LSB;
		q   = lfc_pkg::Q_W'(rnd >>> lfc_pkg::SHIFT);
		if (q > Q_MAX) begin
			res.sample = lfc_pkg::data_t'(Q_MAX);
			res.clip   = 1'b1;
		end else if (q < Q_MIN) begin
			res.sample = lfc_pkg::data_t'(Q_MIN);
			res.clip   = 1'b1;
		end else begin
			res.sample = lfc_pkg::data_t'(q);
			res.clip   = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (coef_mem[i]) coef_mem[i] = '0;
			foreach (hist_mem[i]) hist_mem[i] = '0;
			hist_slot = 0;
			expected_outputs.delete();
			fail_count = 0;
			backlog    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outputs.size() == 0) begin
					$error("output request with no sample pending: sample_out=%0d clipped=%0b",
						sample_out, clipped);
					fail_count++;
				end else begin
					head = expected_outputs.pop_front();
					if (sample_out !== head.sample) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							head.sample, sample_out);
						fail_count++;
					end
					if (clipped !== head.clip) begin
						$error("clipped mismatch: expected %0b, actual %0b", head.clip, clipped);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (kind === lfc_pkg::KIND_TAP) begin
					if (tap_index < lfc_pkg::TAP_LIMIT) coef_mem[tap_index] = tap_value;
				end else begin
					hist_mem[hist_slot] = sample_in;
					expected_outputs.push_back(convolve_history());
					hist_slot = (hist_slot == lfc_pkg::TAPS - 1) ? 0 : hist_slot + 1;
				end
			end
			backlog = expected_outputs.size();
		end
	end

endmodule

[dv/tb_long_fir_convolver_core.sv]
module tb_long_fir_convolver_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	logic           kind;
	lfc_pkg::addr_t tap_index;
	lfc_pkg::data_t tap_value;
	lfc_pkg::data_t sample_in;
	logic           out_valid;
	logic           out_stall;
	lfc_pkg::data_t sample_out;
	logic           clipped;
	int             fail_count;
	int             backlog;

	bit sender_calm;
	bit receiver_calm;
	bit long_hold;

	long_fir_convolver_core u_top (.*);

	lfc_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_q15();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(0, 2)) - 1;
			3, 4: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 511)) - 256;
		endcase
	endfunction

	task automatic offer(logic k, lfc_pkg::addr_t idx, lfc_pkg::data_t tv,
		lfc_pkg::data_t sv, bit no_gap);
		int gap;
		gap = (no_gap || sender_calm) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		tap_index <= idx;
		tap_value <= tv;
		sample_in <= sv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic push_tap(int idx, int val);
		offer(lfc_pkg::KIND_TAP, lfc_pkg::addr_t'(idx), lfc_pkg::data_t'(val),
			lfc_pkg::data_t'($urandom), 1'b0);
	endtask

	task automatic push_sample(int val, bit no_gap);
		offer(lfc_pkg::KIND_SAMPLE, lfc_pkg::addr_t'($urandom), lfc_pkg::data_t'($urandom),
			lfc_pkg::data_t'(val), no_gap);
	endtask

	// output side; one long hold after the 30th result
	initial begin
		int wait_n;
		int taken;
		taken         = 0;
		receiver_calm = 1'b0;
		long_hold     = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 30) begin
				long_hold = 1'b1;
				out_stall <= 1'b1;
				repeat (4000) @(posedge clk);
				long_hold = 1'b0;
			end
			wait_n = receiver_calm ? 0 : $urandom_range(0, 13);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				if ($urandom_range(0, 1)) begin
					@(posedge clk);
					while (!out_valid) @(posedge clk);
				end
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			if (taken % 16 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int count;
		int len;
		int idx;
		bit contiguous;
		sender_calm = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= lfc_pkg::KIND_TAP;
		tap_index <= '0;
		tap_value <= '0;
		sample_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty response, then rounding at the half point
		push_sample(16'sh1234, 1'b0);
		push_tap(0, 1);
		push_sample(16384, 1'b0);
		push_sample(-16384, 1'b0);
		push_sample(-16385, 1'b0);
		// full-scale products, saturation both ways
		push_tap(0, -32768);
		push_sample(-32768, 1'b0);
		push_sample(32767, 1'b0);
		push_tap(1, -32768);
		push_sample(32767, 1'b0);
		// last tap, and indexes past the end that must be dropped
		push_tap(lfc_pkg::TAPS - 1, 32767);
		push_tap(lfc_pkg::TAPS, 32767);
		push_tap(2047, -1);
		push_sample(-1, 1'b0);
		push_tap(0, 32767);
		push_tap(1, 0);
		push_sample(32767, 1'b0);
		push_sample(-32768, 1'b0);
		push_sample(0, 1'b0);

		count = 0;
		while (count < 520) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			if (long_hold) begin
				repeat (4) push_sample(pick_q15(), 1'b1);
				count += 4;
			end else if ($urandom_range(0, 99) < 35) begin
				len        = $urandom_range(1, 20);
				idx        = $urandom_range(0, lfc_pkg::TAPS - 1);
				contiguous = $urandom_range(0, 1);
				repeat (len) begin
					if ($urandom_range(0, 15) == 0) begin
						push_tap($urandom_range(lfc_pkg::TAPS, 2047), pick_q15());
					end else begin
						push_tap(idx, pick_q15());
					end
					count++;
					idx = contiguous ? (idx + 1) % lfc_pkg::TAPS :
						$urandom_range(0, lfc_pkg::TAPS - 1);
				end
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					push_sample(pick_q15(), 1'b0);
					count++;
				end
			end
		end

		in_valid <= 1'b0;
		while (backlog != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (fail_count == 0 && backlog == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
